>>> rtl/rse_pkg.sv
// Package for the rotatable stack engine: sizes, operation codes, FSM states
// and ring-slot helpers. No dependencies.
`default_nettype none

package rse_pkg;

  // Ring geometry
  localparam int DEPTH = 512;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int DW    = 32;

  localparam logic [AW:0]   DEPTH_S = (AW + 1)'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

  // Operation codes
  typedef enum logic [2:0] {
    OP_PUSH     = 3'd0,
    OP_POP      = 3'd1,
    OP_SWAP     = 3'd2,
    OP_ROT_UP   = 3'd3,
    OP_ROT_DOWN = 3'd4
  } op_e;

  // Sequencer states
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_e;

  // Slot of an entry at a given offset above the bottom, wrapped on the ring
  function automatic logic [AW-1:0] slot_add(input logic [AW-1:0] base,
                                             input logic [AW-1:0] off);
    logic [AW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= DEPTH_S) begin
      sum = sum - DEPTH_S;
    end
    return sum[AW-1:0];
  endfunction

endpackage

`default_nettype wire

>>> rtl/rse_ram.sv
// Generic true dual-port RAM with registered read data on both ports.
// No dependencies.
`default_nettype none

module rse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             a_en_i,
  input  wire logic             a_we_i,
  input  wire logic [AW-1:0]    a_addr_i,
  input  wire logic [WIDTH-1:0] a_wdata_i,
  output logic      [WIDTH-1:0] a_rdata_o,
  input  wire logic             b_en_i,
  input  wire logic             b_we_i,
  input  wire logic [AW-1:0]    b_addr_i,
  input  wire logic [WIDTH-1:0] b_wdata_i,
  output logic      [WIDTH-1:0] b_rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and read both ports
  always_ff @(posedge clk_i) begin
    if (a_en_i) begin
      if (a_we_i) begin
        mem[a_addr_i] <= a_wdata_i;
      end
      a_rdata_o <= mem[a_addr_i];
    end
    if (b_en_i) begin
      if (b_we_i) begin
        mem[b_addr_i] <= b_wdata_i;
      end
      b_rdata_o <= mem[b_addr_i];
    end
  end

endmodule

`default_nettype wire

>>> rtl/rotatable_stack_engine.sv
// Top level of the rotatable stack engine: sequencer around a dual-port ring RAM.
// Depends on rse_pkg and rse_ram.
`default_nettype none

// A bounded stack of signed 32-bit words kept in a ring RAM with a bottom
// pointer and an entry count. Raise start_i with op_i and push_value_i while
// busy_o is low; the command is taken at that clock edge. In the accept cycle
// the RAM is read (or, for a push, written); in the next cycle (busy_o high) a
// swap or rotate writes the read data back (a swap through both ports, a
// rotate through the first) and the pointers move. One result follows in the
// cycle after, marked by done_o for exactly one cycle; it cannot be held off,
// so capture it then. A new command may be started in that same cycle. The
// store needs no clearing after reset: only occupied slots are ever read.
module rotatable_stack_engine (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  output logic                           busy_o,
  input  wire logic [2:0]                op_i,
  input  wire logic signed [31:0]        push_value_i,
  output logic                           done_o,
  output logic signed [31:0]             popped_value_o,
  output logic                           popped_valid_o,
  output logic                           overflow_o,
  output logic [rse_pkg::CW-1:0]         occupancy_out_o
);

  import rse_pkg::*;

  state_e        state_q, state_d;
  op_e           op_q;
  logic          ok_q;
  logic [AW-1:0] top_q, sec_q;
  logic [AW-1:0] bottom_q, bottom_d;
  logic [CW-1:0] occ_q, occ_d;

  logic          accept;
  op_e           op_in;
  logic          ok_in;
  logic [AW-1:0] top_slot, sec_slot, push_slot;
  logic [AW-1:0] bot_dec, bot_inc;

  logic          a_en, a_we, b_en, b_we;
  logic [AW-1:0] a_addr, b_addr;
  logic [DW-1:0] a_wdata, b_wdata, a_rdata, b_rdata;

  logic          done_d;
  logic [DW-1:0] pop_val_d;
  logic          pop_vld_d, ovf_d;

  assign accept = start_i && (state_q == ST_IDLE);
  assign op_in  = op_e'(op_i);
  assign busy_o = (state_q == ST_EXEC);

  // Ring slots of the top entries and the neighbors of the bottom
  assign push_slot = slot_add(bottom_q, occ_q[AW-1:0]);
  assign top_slot  = slot_add(bottom_q, AW'(occ_q - CW'(1)));
  assign sec_slot  = slot_add(bottom_q, AW'(occ_q - CW'(2)));
  assign bot_dec   = (bottom_q == '0) ? LAST_SLOT : bottom_q - AW'(1);
  assign bot_inc   = (bottom_q == LAST_SLOT) ? '0 : bottom_q + AW'(1);

  // Decide whether the command has an effect on the current stack
  always_comb begin
    unique case (op_in)
      OP_PUSH:                        ok_in = (occ_q < DEPTH_C);
      OP_POP:                         ok_in = (occ_q != '0);
      OP_SWAP, OP_ROT_UP, OP_ROT_DOWN: ok_in = (occ_q >= CW'(2));
      default:                        ok_in = 1'b0;
    endcase
  end

  // Latch the command and its slots
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= op_in;
      ok_q  <= ok_in;
      top_q <= top_slot;
      sec_q <= sec_slot;
    end
  end

  // Drive the RAM: read or push on accept, write back during execute
  always_comb begin
    a_en    = 1'b0;
    a_we    = 1'b0;
    a_addr  = top_slot;
    a_wdata = push_value_i;
    b_en    = 1'b0;
    b_we    = 1'b0;
    b_addr  = sec_slot;
    b_wdata = a_rdata;
    if (accept) begin
      unique case (op_in)
        OP_PUSH: begin
          a_en   = ok_in;
          a_we   = ok_in;
          a_addr = push_slot;
        end
        OP_POP, OP_ROT_UP: begin
          a_en = ok_in;
        end
        OP_SWAP: begin
          a_en = ok_in;
          b_en = ok_in;
        end
        OP_ROT_DOWN: begin
          a_en   = ok_in;
          a_addr = bottom_q;
        end
        default: begin
          a_en = 1'b0;
        end
      endcase
    end else if (state_q == ST_EXEC && ok_q) begin
      unique case (op_q)
        OP_SWAP: begin
          a_en    = 1'b1;
          a_we    = 1'b1;
          a_addr  = top_q;
          a_wdata = b_rdata;
          b_en    = 1'b1;
          b_we    = 1'b1;
          b_addr  = sec_q;
          b_wdata = a_rdata;
        end
        OP_ROT_UP: begin
          a_en    = 1'b1;
          a_we    = 1'b1;
          a_addr  = bot_dec;
          a_wdata = a_rdata;
        end
        OP_ROT_DOWN: begin
          // old bottom lands one slot above the old top
          a_en    = 1'b1;
          a_we    = 1'b1;
          a_addr  = push_slot;
          a_wdata = a_rdata;
        end
        default: begin
          a_en = 1'b0;
        end
      endcase
    end
  end

  rse_ram #(
    .WIDTH (DW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .a_en_i    (a_en),
    .a_we_i    (a_we),
    .a_addr_i  (a_addr),
    .a_wdata_i (a_wdata),
    .a_rdata_o (a_rdata),
    .b_en_i    (b_en),
    .b_we_i    (b_we),
    .b_addr_i  (b_addr),
    .b_wdata_i (b_wdata),
    .b_rdata_o (b_rdata)
  );

  // Next state, pointer updates and result
  always_comb begin
    state_d   = state_q;
    bottom_d  = bottom_q;
    occ_d     = occ_q;
    done_d    = 1'b0;
    pop_val_d = '0;
    pop_vld_d = 1'b0;
    ovf_d     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d = ST_IDLE;
        done_d  = 1'b1;
        unique case (op_q)
          OP_PUSH: begin
            if (ok_q) begin
              occ_d = occ_q + CW'(1);
            end else begin
              ovf_d = 1'b1;
            end
          end
          OP_POP: begin
            if (ok_q) begin
              occ_d     = occ_q - CW'(1);
              pop_val_d = a_rdata;
              pop_vld_d = 1'b1;
            end
          end
          OP_ROT_UP: begin
            if (ok_q) begin
              bottom_d = bot_dec;
            end
          end
          OP_ROT_DOWN: begin
            if (ok_q) begin
              bottom_d = bot_inc;
            end
          end
          default: begin
            done_d = 1'b1;
          end
        endcase
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      bottom_q <= '0;
      occ_q    <= '0;
      done_o   <= 1'b0;
    end else begin
      state_q  <= state_d;
      bottom_q <= bottom_d;
      occ_q    <= occ_d;
      done_o   <= done_d;
    end
  end

  // Register the result for its one-cycle transfer
  always_ff @(posedge clk_i) begin
    if (done_d) begin
      popped_value_o  <= signed'(pop_val_d);
      popped_valid_o  <= pop_vld_d;
      overflow_o      <= ovf_d;
      occupancy_out_o <= occ_d;
    end
  end

endmodule

`default_nettype wire

>>> test/tb_rotatable_stack_engine.sv
// Self-checking testbench for the rotatable stack engine: a shadow stack
// predicts every result and compares it with what the block reports.
// Depends on rse_pkg and rotatable_stack_engine.
`timescale 1ns / 1ps

module tb_rotatable_stack_engine;

  localparam int unsigned RING = rse_pkg::DEPTH;
  localparam int unsigned CYCLE_LIMIT = 200000;

  // Spare op codes the block must treat as no-ops
  localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

  localparam logic signed [31:0] WORD_MAX  = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] WORD_MIN  = 32'sh8000_0000;
  localparam logic signed [31:0] WORD_ZERO = 32'sh0000_0000;
  localparam logic signed [31:0] WORD_ONES = 32'shFFFF_FFFF;

  typedef struct {
    logic signed [31:0]      value;
    logic                    valid;
    logic                    ovf;
    logic [rse_pkg::CW-1:0]  occ;
  } stack_result_t;

  // Shadow of the ring: tracks contents, bottom slot and entry count
  class stack_mirror;
    logic signed [31:0] ring [RING];
    int unsigned        base;
    int unsigned        entries;
    stack_result_t      awaited[$];
    int unsigned        mismatches;

    function new();
      base = 0;
      entries = 0;
      mismatches = 0;
    endfunction

    function int unsigned slot_of(int unsigned offset);
      return (base + offset) % RING;
    endfunction

    // Apply one accepted command and queue the result it must produce
    function void take_command(logic [2:0] code, logic signed [31:0] word);
      stack_result_t      r;
      logic signed [31:0] held;
      int unsigned        upper;
      int unsigned        lower;
      r.value = '0;
      r.valid = 1'b0;
      r.ovf = 1'b0;
      case (code)
        rse_pkg::OP_PUSH: begin
          if (entries >= RING) begin
            r.ovf = 1'b1;
          end else begin
            ring[slot_of(entries)] = word;
            entries++;
          end
        end
        rse_pkg::OP_POP: begin
          if (entries > 0) begin
            entries--;
            r.value = ring[slot_of(entries)];
            r.valid = 1'b1;
          end
        end
        rse_pkg::OP_SWAP: begin
          if (entries >= 2) begin
            upper = slot_of(entries - 1);
            lower = slot_of(entries - 2);
            held = ring[upper];
            ring[upper] = ring[lower];
            ring[lower] = held;
          end
        end
        rse_pkg::OP_ROT_UP: begin
          // top entry drops below the old bottom
          if (entries >= 2) begin
            held = ring[slot_of(entries - 1)];
            base = (base + RING - 1) % RING;
            ring[base] = held;
          end
        end
        rse_pkg::OP_ROT_DOWN: begin
          // bottom entry moves above the old top
          if (entries >= 2) begin
            held = ring[base];
            base = (base + 1) % RING;
            ring[slot_of(entries - 1)] = held;
          end
        end
        default: begin
        end
      endcase
      r.occ = entries[rse_pkg::CW-1:0];
      awaited.push_back(r);
    endfunction

    // Compare one reported result with the oldest pending one
    function void match_result(logic signed [31:0] value, logic valid, logic ovf,
                               logic [rse_pkg::CW-1:0] occ);
      stack_result_t want;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result value %0d valid %0b overflow %0b occupancy %0d",
                 $time, value, valid, ovf, occ);
        mismatches++;
        return;
      end
      want = awaited.pop_front();
      if (value !== want.value) begin
        $display("%0t: popped_value expected %0d actual %0d", $time, want.value, value);
        mismatches++;
      end
      if (valid !== want.valid) begin
        $display("%0t: popped_valid expected %0b actual %0b", $time, want.valid, valid);
        mismatches++;
      end
      if (ovf !== want.ovf) begin
        $display("%0t: overflow expected %0b actual %0b", $time, want.ovf, ovf);
        mismatches++;
      end
      if (occ !== want.occ) begin
        $display("%0t: occupancy expected %0d actual %0d", $time, want.occ, occ);
        mismatches++;
      end
    endfunction
  endclass

  logic                          clk_i;
  logic                          rst_ni;
  logic                          start_i;
  logic                          busy_o;
  logic [2:0]                    op_i;
  logic signed [31:0]            push_value_i;
  logic                          done_o;
  logic signed [31:0]            popped_value_o;
  logic                          popped_valid_o;
  logic                          overflow_o;
  logic [rse_pkg::CW-1:0]        occupancy_out_o;

  stack_mirror book = new();

  rotatable_stack_engine i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .op_i            (op_i),
    .push_value_i    (push_value_i),
    .done_o          (done_o),
    .popped_value_o  (popped_value_o),
    .popped_valid_o  (popped_valid_o),
    .overflow_o      (overflow_o),
    .occupancy_out_o (occupancy_out_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Check every strobed result at the edge that ends its cycle
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      book.match_result(popped_value_o, popped_valid_o, overflow_o, occupancy_out_o);
    end
  end

  // Hard stop in case the block hangs
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("Regression FAIL");
    $finish;
  end

  function automatic logic signed [31:0] random_word();
    if ($urandom_range(7) != 0) begin
      return $urandom;
    end
    case ($urandom_range(3))
      0: return WORD_MAX;
      1: return WORD_MIN;
      2: return WORD_ZERO;
      default: return WORD_ONES;
    endcase
  endfunction

  // Mixed traffic with pops slightly ahead of pushes
  function automatic logic [2:0] mixed_op();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 30) return rse_pkg::OP_PUSH;
    if (roll < 62) return rse_pkg::OP_POP;
    if (roll < 72) return rse_pkg::OP_SWAP;
    if (roll < 82) return rse_pkg::OP_ROT_UP;
    if (roll < 92) return rse_pkg::OP_ROT_DOWN;
    return 3'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST));
  endfunction

  // Mostly pushes, with reordering ops mixed in, to walk the stack up to full
  function automatic logic [2:0] fill_op();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 88) return rse_pkg::OP_PUSH;
    if (roll < 92) return rse_pkg::OP_SWAP;
    if (roll < 96) return rse_pkg::OP_ROT_UP;
    return rse_pkg::OP_ROT_DOWN;
  endfunction

  // Present one command, optionally after an idle gap, and hold it until transfer
  task automatic issue(input logic [2:0] code, input logic signed [31:0] word,
                       input int unsigned idle_pct);
    @(negedge clk_i);
    if ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clk_i);
    end
    start_i <= 1'b1;
    op_i <= code;
    push_value_i <= word;
    do @(posedge clk_i); while (busy_o);
    book.take_command(code, word);
  endtask

  task automatic run_mixed(input int unsigned count, input int unsigned idle_pct);
    repeat (count) issue(mixed_op(), random_word(), idle_pct);
  endtask

  initial begin
    rst_ni = 1'b0;
    start_i = 1'b0;
    op_i = rse_pkg::OP_PUSH;
    push_value_i = '0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty and single-entry corner cases, extreme values, spare codes
    issue(rse_pkg::OP_POP, random_word(), 0);
    issue(rse_pkg::OP_SWAP, random_word(), 0);
    issue(rse_pkg::OP_ROT_UP, random_word(), 0);
    issue(rse_pkg::OP_ROT_DOWN, random_word(), 0);
    issue(rse_pkg::OP_PUSH, WORD_MAX, 0);
    issue(rse_pkg::OP_SWAP, random_word(), 0);
    issue(rse_pkg::OP_ROT_UP, random_word(), 0);
    issue(rse_pkg::OP_ROT_DOWN, random_word(), 0);
    issue(rse_pkg::OP_PUSH, WORD_MIN, 0);
    issue(rse_pkg::OP_SWAP, random_word(), 0);
    issue(rse_pkg::OP_ROT_UP, random_word(), 0);
    issue(rse_pkg::OP_ROT_DOWN, random_word(), 0);
    issue(rse_pkg::OP_PUSH, WORD_ZERO, 0);
    issue(rse_pkg::OP_PUSH, WORD_ONES, 0);
    issue(rse_pkg::OP_ROT_UP, random_word(), 0);
    issue(rse_pkg::OP_ROT_DOWN, random_word(), 0);
    issue(rse_pkg::OP_SWAP, random_word(), 0);
    issue(OP_SPARE_FIRST, random_word(), 0);
    issue(OP_SPARE_LAST, random_word(), 0);
    repeat (4) issue(rse_pkg::OP_POP, random_word(), 0);
    issue(rse_pkg::OP_POP, random_word(), 0);
    issue(3'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST)), random_word(), 0);

    // Random traffic: no idling, then heavy sender idling
    run_mixed(40, 0);
    run_mixed(40, 52);

    // Fill to capacity with light idling, then push and reorder while full
    while (book.entries < RING) issue(fill_op(), random_word(), 17);
    repeat (6) issue(rse_pkg::OP_PUSH, random_word(), 17);
    repeat (6) issue(3'($urandom_range(rse_pkg::OP_ROT_DOWN, rse_pkg::OP_SWAP)),
                     random_word(), 17);

    // Receiver stalls cannot apply here, so this phase runs without idling
    run_mixed(40, 0);

    @(negedge clk_i);
    start_i <= 1'b0;

    // Drain outstanding results, then let the pipeline settle
    while (book.awaited.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (book.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
